[rtl/hkic_pkg.sv]
package hkic_pkg;

    localparam int KEY_DEPTH   = 32;
    localparam int MAX_BUCKETS = 64;
    localparam int WAYS_MAX    = 4;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int BKT_W       = 6;
    localparam int WAY_W       = 2;
    localparam int ROW_W       = 8 * WAYS_MAX;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [2:0] PATH_EMPTY    = 3'd0;
    localparam logic [2:0] PATH_CACHED   = 3'd1;
    localparam logic [2:0] PATH_RETAINED = 3'd2;
    localparam logic [2:0] PATH_OVERFLOW = 3'd3;
    localparam logic [2:0] PATH_STALE    = 3'd4;

    localparam logic [2:0] ADDR_BUCKET_BITS = 3'd0;
    localparam logic [2:0] ADDR_WAY_COUNT   = 3'd4;

    localparam logic [7:0] OVF_MARK = 8'h80;
    localparam logic [7:0] IDX_MASK = 8'h7f;

    typedef struct packed {
        logic start;
        logic do_clear;
        logic write_ins;
        logic way_read;
        logic way_next;
        logic cap_way;
        logic scan_load;
        logic scan_read;
        logic scan_next;
        logic cap_scan;
        logic emit;
    } hkic_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       occupied;
        logic       way_empty;
        logic       way_stale;
        logic       way_last;
        logic       key_match;
        logic       row_ovf;
        logic       scan_done;
        logic       held;
    } hkic_sts_t;

    function automatic logic [BKT_W-1:0] hash_bucket(input logic [63:0] k,
                                                     input logic [2:0] bits);
        logic [63:0] x;
        logic [2:0]  b;
        logic [BKT_W-1:0] m;
        x = k ^ (k >> 7);
        x = x ^ (x >> 14);
        b = (bits > 3'(BKT_W)) ? 3'(BKT_W) : bits;
        m = BKT_W'((7'd1 << b) - 7'd1);
        return x[BKT_W-1:0] & m;
    endfunction

endpackage

[rtl/hkic_datapath.sv]
module hkic_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [1:0]                    s_func,
    input  logic [63:0]                   s_key,
    input  logic [2:0]                    bucket_bits,
    input  logic [2:0]                    way_count,
    input  hkic_pkg::hkic_cmd_t           cmd,
    output hkic_pkg::hkic_sts_t           sts,
    output logic [hkic_pkg::IDX_W-1:0]    out_index
);
    import hkic_pkg::*;

    logic [63:0]      key_mem [KEY_DEPTH];
    logic [ROW_W-1:0] row_mem [MAX_BUCKETS];

    logic [1:0]       func_reg;
    logic [63:0]      key_reg;
    logic [BKT_W-1:0] bkt_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]      occ_reg, occ_next;
    logic [WAY_W-1:0] way_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [63:0]      kd_reg;
    logic [IDX_W-1:0] idx_reg, out_idx_reg;
    logic [2:0]       ways;
    logic [WAY_W-1:0] last_way;
    logic [BKT_W-1:0] bkt;
    logic [6:0]       wv, cand, new_idx;
    logic [IDX_W-1:0] rd_addr;
    logic             held, ovf;
    logic [ROW_W-1:0] new_row;

    assign ways = (way_count == 3'd0) ? 3'd1 :
                  (way_count > 3'(WAYS_MAX)) ? 3'(WAYS_MAX) : way_count;
    assign last_way = WAY_W'(ways - 3'd1);
    assign bkt      = hash_bucket(s_key, bucket_bits);
    assign wv       = row_reg[{way_reg, 3'b000} +: 7];
    assign cand     = wv - 7'd1;
    assign new_idx  = {2'b00, cnt_reg[IDX_W-1:0]} + 7'd1;
    assign rd_addr  = cmd.way_read ? cand[IDX_W-1:0] : scan_reg[IDX_W-1:0];

    always_comb begin
        logic stop;
        stop = 1'b0;
        held = 1'b0;
        for (int w = 0; w < WAYS_MAX; w++) begin
            if (w >= int'(ways) || row_reg[8*w +: 7] == 7'd0) stop = 1'b1;
            if (!stop && row_reg[8*w +: 7] == {2'b00, scan_reg[IDX_W-1:0]} + 7'd1) held = 1'b1;
        end
    end

    always_comb begin
        ovf = row_reg[7] || (row_reg[{last_way, 3'b000} +: 7] != 7'd0);
        new_row = row_reg;
        if (!occ_reg[bkt_reg]) begin
            for (int w = 1; w < WAYS_MAX; w++) begin
                if (w < int'(ways)) new_row[8*w +: 8] = 8'd0;
            end
            new_row[7:0] = {1'b0, new_idx};
        end else begin
            for (int w = 1; w < WAYS_MAX; w++) begin
                if (w < int'(ways)) new_row[8*w +: 8] = row_reg[8*(w-1) +: 8] & IDX_MASK;
            end
            new_row[7:0] = {1'b0, new_idx} | (ovf ? OVF_MARK : 8'h00);
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        occ_next = occ_reg;
        if (cmd.do_clear) begin
            cnt_next = '0;
            occ_next = '0;
        end else if (cmd.write_ins) begin
            cnt_next = cnt_reg + CNT_W'(1);
            occ_next = occ_reg | (64'd1 << bkt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            occ_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            func_reg <= s_func;
            key_reg  <= s_key;
            bkt_reg  <= bkt;
            row_reg  <= row_mem[bkt];
        end
        if (cmd.write_ins) begin
            key_mem[cnt_reg[IDX_W-1:0]] <= key_reg;
            row_mem[bkt_reg]            <= new_row;
        end
        if (cmd.way_read || cmd.scan_read) begin
            kd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            way_reg <= '0;
        end else if (cmd.way_next) begin
            way_reg <= way_reg + WAY_W'(1);
        end
        if (cmd.scan_load) begin
            scan_reg <= cnt_reg - CNT_W'(1);
        end else if (cmd.scan_next) begin
            scan_reg <= scan_reg - CNT_W'(1);
        end
        if (cmd.start) begin
            idx_reg <= '0;
        end else if (cmd.write_ins) begin
            idx_reg <= cnt_reg[IDX_W-1:0];
        end else if (cmd.cap_way) begin
            idx_reg <= cand[IDX_W-1:0];
        end else if (cmd.cap_scan) begin
            idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (cmd.emit) begin
            out_idx_reg <= idx_reg;
        end
    end

    always_comb begin
        sts.func      = func_reg;
        sts.full      = cnt_reg >= CNT_W'(KEY_DEPTH);
        sts.occupied  = occ_reg[bkt_reg];
        sts.way_empty = wv == 7'd0;
        sts.way_stale = wv > {1'b0, cnt_reg};
        sts.way_last  = {1'b0, way_reg} == ways - 3'd1;
        sts.key_match = kd_reg == key_reg;
        sts.row_ovf   = row_reg[7];
        sts.scan_done = scan_reg[CNT_W-1];
        sts.held      = held;
    end

    assign out_index = out_idx_reg;
endmodule

[rtl/hkic_ctrl.sv]
module hkic_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  hkic_pkg::hkic_sts_t sts,
    output hkic_pkg::hkic_cmd_t cmd,
    output logic                m_found,
    output logic [2:0]          m_path,
    output logic                m_rejected
);
    import hkic_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISP     = 7'b0000010,
        S_WAY_RD   = 7'b0000100,
        S_WAY_CMP  = 7'b0001000,
        S_SCAN_RD  = 7'b0010000,
        S_SCAN_CMP = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] path_reg, path_next;
    logic       hit_reg, hit_next, rej_reg, rej_next;
    logic       mv_reg, mv_next;
    logic       out_found_reg, out_rej_reg;
    logic [2:0] out_path_reg;

    always_comb begin
        state_next = state_reg;
        path_next  = path_reg;
        hit_next   = hit_reg;
        rej_next   = rej_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                path_next  = PATH_EMPTY;
                hit_next   = 1'b0;
                rej_next   = 1'b0;
                state_next = S_DONE;
                unique case (sts.func)
                    FUNC_CLEAR: cmd.do_clear = 1'b1;
                    FUNC_INSERT: begin
                        if (sts.full) begin
                            rej_next = 1'b1;
                        end else begin
                            cmd.write_ins = 1'b1;
                            hit_next      = 1'b1;
                        end
                    end
                    FUNC_LOOKUP: begin
                        if (sts.occupied) state_next = S_WAY_RD;
                    end
                    default: ;
                endcase
            end
            S_WAY_RD: begin
                if (sts.way_empty) begin
                    if (sts.row_ovf) begin
                        path_next     = PATH_OVERFLOW;
                        cmd.scan_load = 1'b1;
                        state_next    = S_SCAN_RD;
                    end else begin
                        path_next  = PATH_RETAINED;
                        state_next = S_DONE;
                    end
                end else if (sts.way_stale) begin
                    path_next     = PATH_STALE;
                    cmd.scan_load = 1'b1;
                    state_next    = S_SCAN_RD;
                end else begin
                    cmd.way_read = 1'b1;
                    state_next   = S_WAY_CMP;
                end
            end
            S_WAY_CMP: begin
                if (sts.key_match) begin
                    path_next   = PATH_CACHED;
                    hit_next    = 1'b1;
                    cmd.cap_way = 1'b1;
                    state_next  = S_DONE;
                end else if (sts.way_last) begin
                    if (sts.row_ovf) begin
                        path_next     = PATH_OVERFLOW;
                        cmd.scan_load = 1'b1;
                        state_next    = S_SCAN_RD;
                    end else begin
                        path_next  = PATH_RETAINED;
                        state_next = S_DONE;
                    end
                end else begin
                    cmd.way_next = 1'b1;
                    state_next   = S_WAY_RD;
                end
            end
            S_SCAN_RD: begin
                if (sts.scan_done) begin
                    state_next = S_DONE;
                end else if (path_reg == PATH_OVERFLOW && sts.held) begin
                    cmd.scan_next = 1'b1;
                end else begin
                    cmd.scan_read = 1'b1;
                    state_next    = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (sts.key_match) begin
                    hit_next     = 1'b1;
                    cmd.cap_scan = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        path_reg <= path_next;
        hit_reg  <= hit_next;
        rej_reg  <= rej_next;
        if (cmd.emit) begin
            out_found_reg <= hit_reg;
            out_path_reg  <= path_reg;
            out_rej_reg   <= rej_reg;
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = mv_reg;
    assign m_found    = out_found_reg;
    assign m_path     = out_path_reg;
    assign m_rejected = out_rej_reg;
endmodule

[rtl/hashed_key_index_cache_core.sv]
// Clear, insert and a lookup of an empty bucket finish at dispatch; other lookups walk the
// ways until a hit or a miss, and a store scan compares entries newest first, skipping
// entries already held in the row on the overflow path.
// Only one beat is in flight: the next beat is taken once the previous result is parked
// in the output register, which waits while an unaccepted result is held and m_ready is low.
// Reset (aresetn low, synchronous) empties the key count and bucket bitmap, sets bucket_bits
// to 6 and way_count to 4; key store and index cache are undefined until written.
module hashed_key_index_cache_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [63:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [4:0]  m_index,
    output logic [2:0]  m_path,
    output logic        m_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hkic_pkg::*;

    logic [2:0] bb_reg, wc_reg;
    hkic_cmd_t  cmd;
    hkic_sts_t  sts;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bb_reg <= 3'd6;
            wc_reg <= 3'd4;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_BUCKET_BITS) bb_reg <= pwdata[2:0];
            else if (paddr == ADDR_WAY_COUNT) wc_reg <= pwdata[2:0];
        end
    end
    assign prdata = (paddr == ADDR_BUCKET_BITS) ? {29'd0, bb_reg} :
                    (paddr == ADDR_WAY_COUNT) ? {29'd0, wc_reg} : 32'd0;

    hkic_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_func(s_func), .s_key(s_key),
        .bucket_bits(bb_reg), .way_count(wc_reg),
        .cmd(cmd), .sts(sts), .out_index(m_index)
    );

    hkic_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd),
        .m_found(m_found), .m_path(m_path), .m_rejected(m_rejected)
    );
endmodule

[tb/hashed_key_index_cache_core_check.sv]
module hashed_key_index_cache_core_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [63:0] s_key,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_found,
    input  logic [4:0]  m_index,
    input  logic [2:0]  m_path,
    input  logic        m_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hkic_pkg::*;

    typedef struct packed {
        logic       found;
        logic [4:0] index;
        logic [2:0] path;
        logic       rejected;
    } lookup_result_t;

    logic [63:0]    keys [KEY_DEPTH];
    logic [7:0]     rows [MAX_BUCKETS * WAYS_MAX];
    int             key_total;
    logic [63:0]    occupied;
    logic [2:0]     bucket_bits;
    logic [2:0]     way_count;
    lookup_result_t expected_results [$];

    function automatic int bucket_of(input logic [63:0] k);
        logic [63:0] x;
        int          nbits;
        nbits = (bucket_bits > 3'd6) ? 6 : int'(bucket_bits);
        x = k ^ (k >> 7);
        x = x ^ (x >> 14);
        return int'(x & ((64'd1 << nbits) - 64'd1));
    endfunction

    function automatic int ways_used();
        if (way_count == 3'd0) return 1;
        if (way_count > 3'd4) return WAYS_MAX;
        return int'(way_count);
    endfunction

    function automatic int newest_match(input logic [63:0] k);
        for (int i = key_total - 1; i >= 0; i--)
            if (keys[i] == k) return i;
        return -1;
    endfunction

    function automatic bit row_has(input int base, input int nways, input int idx);
        int v;
        for (int w = 0; w < nways; w++) begin
            v = int'(rows[base + w] & IDX_MASK);
            if (v == 0) return 0;
            if (v - 1 == idx) return 1;
        end
        return 0;
    endfunction

    function automatic lookup_result_t predict_step(input logic [1:0] f,
                                                    input logic [63:0] k);
        lookup_result_t r;
        int b, base, nways, v, hit;
        bit ovf;
        r = '0;
        b = bucket_of(k);
        base = b * WAYS_MAX;
        nways = ways_used();
        hit = -1;
        unique case (f)
            FUNC_CLEAR: begin
                key_total = 0;
                occupied = '0;
            end
            FUNC_INSERT: begin
                if (key_total >= KEY_DEPTH) begin
                    r.rejected = 1'b1;
                end else begin
                    keys[key_total] = k;
                    if (!occupied[b]) begin
                        rows[base] = 8'(key_total + 1) & IDX_MASK;
                        for (int w = 1; w < nways; w++) rows[base + w] = 8'd0;
                        occupied[b] = 1'b1;
                    end else begin
                        ovf = (rows[base] & OVF_MARK) != 0
                            || (rows[base + nways - 1] & IDX_MASK) != 0;
                        for (int w = nways - 1; w > 0; w--)
                            rows[base + w] = rows[base + w - 1] & IDX_MASK;
                        rows[base] = (8'(key_total + 1) & IDX_MASK) | (ovf ? OVF_MARK : 8'd0);
                    end
                    r.found = 1'b1;
                    r.index = 5'(key_total);
                    key_total++;
                end
            end
            FUNC_LOOKUP: begin
                r.path = PATH_EMPTY;
                if (occupied[b]) begin
                    for (int w = 0; w < nways && r.path == PATH_EMPTY; w++) begin
                        v = int'(rows[base + w] & IDX_MASK);
                        if (v == 0) break;
                        if (v - 1 >= key_total) begin
                            r.path = PATH_STALE;
                            hit = newest_match(k);
                        end else if (keys[v - 1] == k) begin
                            r.path = PATH_CACHED;
                            hit = v - 1;
                        end
                    end
                    if (r.path == PATH_EMPTY) begin
                        if ((rows[base] & OVF_MARK) == 0) begin
                            r.path = PATH_RETAINED;
                        end else begin
                            r.path = PATH_OVERFLOW;
                            for (int i = key_total - 1; i >= 0 && hit < 0; i--)
                                if (!row_has(base, nways, i) && keys[i] == k) hit = i;
                        end
                    end
                end
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.index = 5'(hit);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        lookup_result_t e;
        if (!aresetn) begin
            key_total = 0;
            occupied = '0;
            bucket_bits <= 3'd6;
            way_count <= 3'd4;
            fail_count <= 0;
            expected_results.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_BUCKET_BITS) bucket_bits <= pwdata[2:0];
                if (paddr == ADDR_WAY_COUNT) way_count <= pwdata[2:0];
            end
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), predict_step(s_func, s_key));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_found !== e.found || m_index !== e.index
                        || m_path !== e.path || m_rejected !== e.rejected) begin
                        if (m_found !== e.found)
                            $error("found: expected %0d, got %0d", e.found, m_found);
                        if (m_index !== e.index)
                            $error("index: expected %0d, got %0d", e.index, m_index);
                        if (m_path !== e.path)
                            $error("path: expected %0d, got %0d", e.path, m_path);
                        if (m_rejected !== e.rejected)
                            $error("rejected: expected %0d, got %0d", e.rejected, m_rejected);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

[tb/hashed_key_index_cache_core_test.sv]
module hashed_key_index_cache_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hkic_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_CLEAR;
    logic [63:0] s_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic [4:0]  m_index;
    logic [2:0]  m_path;
    logic        m_rejected;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    int  beats_sent = 0;
    int  settings = 0;
    bit  hold_off = 0;

    always #1 aclk = ~aclk;

    hashed_key_index_cache_core i_dut (.*);

    hashed_key_index_cache_core_check i_check (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("hashed_key_index_cache_core verification failed");
            $finish;
        end
    end

    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send(input logic [1:0] f, input logic [63:0] k, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_func <= f;
        s_key <= k;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [2:0] bb, input logic [2:0] wc);
        reg_write(ADDR_BUCKET_BITS, {29'd0, bb});
        reg_write(ADDR_WAY_COUNT, {29'd0, wc});
        settings++;
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [63:0] pool [8];
        logic [1:0]  f;
        int          pick, clr_pct, burst;
        bit          fast;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // write every cache byte once so later way_count changes see defined rows
        for (int i = 0; i < 64; i++) begin
            if (i == 32) send(FUNC_CLEAR, '0, 0);
            send(FUNC_INSERT, 64'(i), 0);
        end
        send(FUNC_CLEAR, '0, 0);
        drain();

        configure(3'd0, 3'd1);
        send(FUNC_LOOKUP, '1, 0);
        send(FUNC_INSERT, '0, 0);
        send(FUNC_LOOKUP, 64'h5555_5555_5555_5555, 0);
        send(FUNC_INSERT, '1, 0);
        send(FUNC_INSERT, 64'h5555_5555_5555_5555, 0);
        send(FUNC_LOOKUP, '0, 0);
        send(FUNC_LOOKUP, '1, 0);
        send(FUNC_LOOKUP, 64'h5555_5555_5555_5555, 0);
        send(FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        send(FUNC_UNUSED, '1, 0);
        drain();
        configure(3'd7, 3'd7);
        send(FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        send(FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        send(FUNC_LOOKUP, '1, 0);
        send(FUNC_CLEAR, '1, 0);
        send(FUNC_LOOKUP, '0, 0);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            unique case (phase)
                0: configure(3'd0, 3'd0);
                1: configure(3'd6, 3'd4);
                2: configure(3'd7, 3'd1);
                default: configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            endcase
            for (int i = 0; i < 8; i++)
                pool[i] = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 255)) : rand_key();
            clr_pct = (phase % 3 == 0) ? 0 : $urandom_range(1, 5);
            if (phase == 3) hold_off = 1;
            fast = (phase == 3);
            burst = 100;
            for (int n = 0; n < burst; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < clr_pct) f = FUNC_CLEAR;
                else if (pick < clr_pct + 2) f = FUNC_UNUSED;
                else if (pick < 55) f = FUNC_INSERT;
                else f = FUNC_LOOKUP;
                send(f, ($urandom_range(0, 4) == 0) ? rand_key() : pool[$urandom_range(0, 7)],
                     fast);
            end
            drain();
        end

        $display("%0d beats sent over %0d register settings, all paths and full-store inserts",
                 beats_sent, settings);
        $display("exercised under random stalls and one long receiver hold-off");
        if (fail_count == 0) begin
            $display("hashed_key_index_cache_core verification clean");
        end else begin
            $display("hashed_key_index_cache_core verification failed");
        end
        $finish;
    end

endmodule
